[sv/wis_pkg.sv]
// Shared types and constants for the windowed intensity sum core.
// Depends on nothing; every other file in this folder imports it.
package wis_pkg;

    // Spectrum store size and the widths that follow from it.
    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;

    // Field widths.
    localparam int MZ_W  = 32;
    localparam int INT_W = 32;
    localparam int SUM_W = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Depth of the request queue between the front and back parts.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    // Input kind codes.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Classified operation handed to the back part.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [MZ_W-1:0]  point_mz;
        logic [INT_W-1:0] point_intensity;
        logic [MZ_W-1:0]  target_mz;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] intensity_sum;
        logic             saturated;
    } t_res;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SRCH,
        ST_CMP,
        ST_SUMRD,
        ST_SUMCHK,
        ST_EMIT
    } t_state;

endpackage

[sv/wis_front.sv]
// Front part: accepts input requests, classifies them and queues them.
// Depends on wis_pkg for the request struct and kind codes.
module wis_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_kind,
    input  logic [wis_pkg::MZ_W-1:0]  i_point_mz,
    input  logic [wis_pkg::INT_W-1:0] i_point_intensity,
    input  logic [wis_pkg::MZ_W-1:0]  i_target_mz,
    output wis_pkg::t_cmd             o_cmd,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_pop
);
    import wis_pkg::*;

    t_cmd                  r_queue [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                  accept;
    logic                  keep;
    logic                  do_pop;
    t_cmd                  cls_cmd;

    // Classify the incoming request; the unused kind is dropped here.
    always_comb begin
        keep                    = 1'b1;
        cls_cmd.op              = OP_CLEAR;
        cls_cmd.point_mz        = i_point_mz;
        cls_cmd.point_intensity = i_point_intensity;
        cls_cmd.target_mz       = i_target_mz;
        case (i_kind)
            KIND_CLEAR:  cls_cmd.op = OP_CLEAR;
            KIND_APPEND: cls_cmd.op = OP_APPEND;
            KIND_QUERY:  cls_cmd.op = OP_QUERY;
            default:     keep = 1'b0;
        endcase
    end

    assign full        = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign accept      = push && !full && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = accept ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + CMDQ_CNT_W'(accept) - CMDQ_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

[sv/wis_back.sv]
// Back part: spectrum stores, lower-bound search and windowed summing.
// Depends on wis_pkg for the request, result and state types.
module wis_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [wis_pkg::MZ_W-1:0] i_window_width,
    input  wis_pkg::t_cmd            i_cmd,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_pop,
    output wis_pkg::t_res            o_res,
    output logic                     o_res_push,
    input  logic                     i_res_full
);
    import wis_pkg::*;

    // Spectrum memories, read data registered.
    logic [MZ_W-1:0]  r_mz_mem  [MAX_POINTS];
    logic [INT_W-1:0] r_int_mem [MAX_POINTS];
    logic [MZ_W-1:0]  r_mz_rd;
    logic [INT_W-1:0] r_int_rd;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [ADDR_W-1:0] r_mid, n_mid;
    logic [MZ_W-1:0]  r_start, n_start;
    logic [MZ_W-1:0]  r_end, n_end;
    logic [SUM_W-1:0] r_sum, n_sum;

    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Decisions shared by the next-state and output blocks.
    logic [MZ_W-1:0]  half;
    logic [MZ_W:0]    end_wide;
    logic [MZ_W-1:0]  win_start;
    logic [MZ_W-1:0]  win_end;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W:0]   mid_sum;
    logic             search_more;
    logic             idx_in_range;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic             count_zero;
    logic             store_full;

    assign half      = i_window_width >> 1;
    assign win_start = (i_cmd.target_mz >= half) ? i_cmd.target_mz - half : '0;
    assign end_wide  = {1'b0, i_cmd.target_mz} + {1'b0, half};
    assign win_end   = end_wide[MZ_W] ? {MZ_W{1'b1}} : end_wide[MZ_W-1:0];

    assign last_idx     = r_count - 1'b1;
    assign mid_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign search_more  = ({1'b0, r_lo} + 1'b1) < {1'b0, r_hi};
    assign idx_in_range = (r_idx < r_count);
    assign sum_wide     = {1'b0, r_sum} + (SUM_W + 1)'(r_int_rd);
    assign sum_sat      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign count_zero   = (r_count == '0);
    assign store_full   = (r_count == CNT_W'(MAX_POINTS));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_QUERY) begin
                    n_state = count_zero ? ST_EMIT : ST_FIRST;
                end
            end
            ST_FIRST:  n_state = (r_start <= r_mz_rd) ? ST_SUMRD : ST_LAST;
            ST_LAST:   n_state = (r_start >= r_mz_rd) ? ST_EMIT : ST_SRCH;
            ST_SRCH:   n_state = search_more ? ST_CMP : ST_SUMRD;
            ST_CMP:    n_state = ST_SRCH;
            ST_SUMRD:  n_state = idx_in_range ? ST_SUMCHK : ST_EMIT;
            ST_SUMCHK: n_state = (r_mz_rd <= r_end) ? ST_SUMRD : ST_EMIT;
            ST_EMIT:   n_state = i_res_full ? ST_EMIT : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath updates, memory controls and handshake outputs.
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_start    = r_start;
        n_end      = r_end;
        n_sum      = r_sum;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_CLEAR: n_count = '0;
                        OP_APPEND: begin
                            if (!store_full) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            n_start = win_start;
                            n_end   = win_end;
                            n_sum   = '0;
                            n_idx   = '0;
                            rd_en   = !count_zero;
                        end
                        default: n_count = r_count;
                    endcase
                end
            end
            ST_FIRST: begin
                // Start at or below the first point sums from index zero.
                if (!(r_start <= r_mz_rd)) begin
                    rd_en   = 1'b1;
                    rd_addr = last_idx[ADDR_W-1:0];
                end
            end
            ST_LAST: begin
                n_lo = '0;
                n_hi = last_idx;
            end
            ST_SRCH: begin
                if (search_more) begin
                    n_mid   = mid_sum[ADDR_W:1];
                    rd_en   = 1'b1;
                    rd_addr = mid_sum[ADDR_W:1];
                end else begin
                    n_idx = r_hi;
                end
            end
            ST_CMP: begin
                if (r_start <= r_mz_rd) begin
                    n_hi = CNT_W'(r_mid);
                end else begin
                    n_lo = CNT_W'(r_mid);
                end
            end
            ST_SUMRD: begin
                if (idx_in_range) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[ADDR_W-1:0];
                end
            end
            ST_SUMCHK: begin
                if (r_mz_rd <= r_end) begin
                    n_sum = sum_sat;
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EMIT:  o_res_push = !i_res_full;
            default:  o_res_push = 1'b0;
        endcase
    end

    assign o_res.intensity_sum = r_sum;
    assign o_res.saturated     = (r_sum == SUM_MAX);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_start <= n_start;
        r_end   <= n_end;
        r_sum   <= n_sum;
    end

    // Spectrum memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mz_mem[r_count[ADDR_W-1:0]]  <= i_cmd.point_mz;
            r_int_mem[r_count[ADDR_W-1:0]] <= i_cmd.point_intensity;
        end
        if (rd_en) begin
            r_mz_rd  <= r_mz_mem[rd_addr];
            r_int_rd <= r_int_mem[rd_addr];
        end
    end

endmodule

[sv/wis_out.sv]
// Result queue: holds finished sums until the consumer takes them.
// Depends on wis_pkg for the result struct.
module wis_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wis_pkg::t_res             i_res,
    input  logic                      i_res_push,
    output logic                      o_res_full,
    output logic                      empty,
    input  logic                      pop,
    output logic [wis_pkg::SUM_W-1:0] o_intensity_sum,
    output logic                      o_saturated
);
    import wis_pkg::*;

    t_res       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push;
    logic       do_pop;
    t_res       head;

    assign o_res_full      = (r_cnt == 2'd2);
    assign empty           = (r_cnt == 2'd0);
    assign do_push         = i_res_push && !o_res_full;
    assign do_pop          = pop && !empty;
    assign head            = r_slot[r_rd_ptr];
    assign o_intensity_sum = head.intensity_sum;
    assign o_saturated     = head.saturated;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

[sv/windowed_intensity_sum_core.sv]
// Top level of the windowed intensity sum core.
// Depends on wis_pkg, wis_front, wis_back and wis_out.
//
//   Channel   Handshake               Carries
//   input     push / full             kind, point_mz, point_intensity, target_mz
//   result    empty / pop             intensity_sum, saturated
//   config    cfg_valid / cfg_ready   window_width
//
// Clear and append requests are handled in the back part's idle state. A query
// runs a lower-bound search, then reads the window's points one by one through
// the single read port of the spectrum memories; an empty spectrum gives a zero
// sum. Reset is synchronous and active low; it empties both queues and the
// spectrum. Up to four requests queue ahead of the back part, two results behind.
module windowed_intensity_sum_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_kind,
    input  logic [wis_pkg::MZ_W-1:0]  i_point_mz,
    input  logic [wis_pkg::INT_W-1:0] i_point_intensity,
    input  logic [wis_pkg::MZ_W-1:0]  i_target_mz,
    output logic                      empty,
    input  logic                      pop,
    output logic [wis_pkg::SUM_W-1:0] o_intensity_sum,
    output logic                      o_saturated,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [wis_pkg::MZ_W-1:0]  i_cfg_window_width
);
    import wis_pkg::*;

    logic [MZ_W-1:0] r_window_width;
    t_cmd            cmd;
    logic            cmd_valid;
    logic            cmd_pop;
    t_res            res;
    logic            res_push;
    logic            res_full;

    // Window width register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_width <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_width <= i_cfg_window_width;
        end
    end

    wis_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_kind            (i_kind),
        .i_point_mz        (i_point_mz),
        .i_point_intensity (i_point_intensity),
        .i_target_mz       (i_target_mz),
        .o_cmd             (cmd),
        .o_cmd_valid       (cmd_valid),
        .i_cmd_pop         (cmd_pop)
    );

    wis_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_width (r_window_width),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .o_res          (res),
        .o_res_push     (res_push),
        .i_res_full     (res_full)
    );

    wis_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (res),
        .i_res_push      (res_push),
        .o_res_full      (res_full),
        .empty           (empty),
        .pop             (pop),
        .o_intensity_sum (o_intensity_sum),
        .o_saturated     (o_saturated)
    );

endmodule
